// ===== hw/rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure/temperature compensation pipe.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int CountW = 24;
  localparam int CalW   = 16;
  localparam int TempW  = 19;
  localparam int PressW = 28;
  localparam int AccW   = 40;
  localparam int TiW    = 17;
  localparam int SqW    = 35;

  // reference temperature and cold-branch bounds, as offsets of dev = temp - 2000
  localparam logic signed [TempW-1:0] TempRef  = 19'sd2000;
  localparam logic signed [TempW-1:0] ColdOfs  = 19'sd3500;
  localparam logic signed [TempW-1:0] VcoldDev = -19'sd3500;

  typedef enum logic [2:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CalW-1:0] c1;
    logic [CalW-1:0] c2;
    logic [CalW-1:0] c3;
    logic [CalW-1:0] c4;
    logic [CalW-1:0] c5;
    logic [CalW-1:0] c6;
  } cal_t;

  typedef struct packed {
    logic                    vld;
    logic                    zero;
    logic [CountW-1:0]       d1;
    logic signed [TempW-1:0] temp;
    logic signed [TempW-1:0] dev;
    logic signed [TempW-1:0] cold;
    logic [TiW-1:0]          ti;
    logic signed [AccW-1:0]  off1;
    logic signed [AccW-1:0]  sens1;
  } front_t;

  typedef struct packed {
    logic                    vld;
    logic                    zero;
    logic [CountW-1:0]       d1;
    logic signed [TempW-1:0] t2;
    logic signed [AccW-1:0]  off;
    logic signed [AccW-1:0]  sens;
  } second_t;

endpackage

// ===== hw/rtl/ptc_front.sv =====
// ----------------------------------------------------------------------------
// ptc_front
// First-order stages: dT, the four products on dT, temperature and first-order
// offset and sensitivity.
// ----------------------------------------------------------------------------
module ptc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start_acc,
  input  logic [ptc_pkg::CountW-1:0]     pressure_count,
  input  logic [ptc_pkg::CountW-1:0]     temperature_count,
  input  ptc_pkg::cal_t                  cal,
  output ptc_pkg::front_t                front
);
  import ptc_pkg::*;

  // stage 1
  logic              v1;
  logic              z1;
  logic [CountW-1:0] d1_1;
  logic signed [24:0] dt1;

  // stage 2
  logic              v2;
  logic              z2;
  logic [CountW-1:0] d1_2;
  logic signed [41:0] mt2;
  logic signed [41:0] mo2;
  logic signed [41:0] ms2;
  logic [47:0]       dtsq2;

  logic signed [41:0] mt_c;
  logic signed [41:0] mo_c;
  logic signed [41:0] ms_c;
  logic signed [49:0] sq_c;

  // stage 3 combinational
  logic signed [TempW-1:0] dev_c;
  logic [49:0]             tri_c;
  logic [TiW-1:0]          ti_c;
  front_t                  front_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      front.vld <= 1'b0;
    end else begin
      v1 <= start_acc;
      v2 <= v1;
      front <= front_next;
    end
  end

  always_ff @(posedge clk) begin
    z1    <= (pressure_count == '0) || (temperature_count == '0);
    d1_1  <= pressure_count;
    dt1   <= $signed({1'b0, temperature_count}) - $signed({1'b0, cal.c5, 8'b0});
    z2    <= z1;
    d1_2  <= d1_1;
    mt2   <= mt_c;
    mo2   <= mo_c;
    ms2   <= ms_c;
    dtsq2 <= sq_c[47:0];
  end

  assign mt_c = dt1 * $signed({1'b0, cal.c6});
  assign mo_c = dt1 * $signed({1'b0, cal.c4});
  assign ms_c = dt1 * $signed({1'b0, cal.c3});
  assign sq_c = dt1 * dt1;

  always_comb begin
    dev_c = mt2[41:23];
    tri_c = {2'b0, dtsq2} + {1'b0, dtsq2, 1'b0};
    if (dev_c[TempW-1]) begin
      ti_c = tri_c[49:33];
    end else begin
      ti_c = {5'b0, dtsq2[47:36]};
    end
    front_next.vld   = v2;
    front_next.zero  = z2;
    front_next.d1    = d1_2;
    front_next.dev   = dev_c;
    front_next.temp  = dev_c + TempRef;
    front_next.cold  = dev_c + ColdOfs;
    front_next.ti    = ti_c;
    front_next.off1  = $signed({8'b0, cal.c2, 16'b0}) + $signed({{5{mo2[41]}}, mo2[41:7]});
    front_next.sens1 = $signed({9'b0, cal.c1, 15'b0}) + $signed({{6{ms2[41]}}, ms2[41:8]});
  end

endmodule

// ===== hw/rtl/ptc_second.sv =====
// ----------------------------------------------------------------------------
// ptc_second
// Second-order correction: squares of the deviation, then the cold, very-cold
// and warm terms applied to temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module ptc_second (
  input  logic             clk,
  input  logic             rst,
  input  ptc_pkg::front_t  front,
  output ptc_pkg::second_t second
);
  import ptc_pkg::*;

  // stage 4
  front_t         f4;
  logic [SqW-1:0] devsq4;
  logic [SqW-1:0] coldsq4;
  logic           vcold4;

  logic signed [37:0] devsq_c;
  logic signed [37:0] coldsq_c;

  // stage 5 combinational
  logic [AccW-1:0] dsq;
  logic [AccW-1:0] csq;
  logic [AccW-1:0] offi;
  logic [AccW-1:0] sensi;
  second_t         second_next;

  assign devsq_c  = front.dev * front.dev;
  assign coldsq_c = front.cold * front.cold;

  always_ff @(posedge clk) begin
    if (rst) begin
      f4.vld     <= 1'b0;
      second.vld <= 1'b0;
    end else begin
      f4     <= front;
      second <= second_next;
    end
  end

  always_ff @(posedge clk) begin
    devsq4  <= devsq_c[SqW-1:0];
    coldsq4 <= coldsq_c[SqW-1:0];
    vcold4  <= front.dev < VcoldDev;
  end

  always_comb begin
    dsq = {5'b0, devsq4};
    csq = {5'b0, coldsq4};
    if (f4.dev[TempW-1]) begin
      offi  = (((dsq << 1) + dsq) >> 1) + (vcold4 ? ((csq << 3) - csq) : '0);
      sensi = (((dsq << 2) + dsq) >> 3) + (vcold4 ? (csq << 2) : '0);
    end else begin
      offi  = dsq >> 4;
      sensi = '0;
    end
    second_next.vld  = f4.vld;
    second_next.zero = f4.zero;
    second_next.d1   = f4.d1;
    second_next.t2   = f4.temp - $signed({2'b0, f4.ti});
    second_next.off  = f4.off1 - $signed(offi);
    second_next.sens = f4.sens1 - $signed(sensi);
  end

endmodule

// ===== hw/rtl/ptc_press.sv =====
// ----------------------------------------------------------------------------
// ptc_press
// Pressure stages: D1 times sensitivity as two partial products, their sum,
// then the offset subtraction, final scaling and output register.
// ----------------------------------------------------------------------------
module ptc_press (
  input  logic                                clk,
  input  logic                                rst,
  input  ptc_pkg::second_t                    second,
  output logic                                done,
  output logic                                valid_res,
  output logic signed [ptc_pkg::TempW-1:0]    temperature_centideg,
  output logic signed [ptc_pkg::PressW-1:0]   pressure_tens_pa
);
  import ptc_pkg::*;

  // stage 6
  logic                    v6;
  logic                    z6;
  logic signed [TempW-1:0] t2_6;
  logic signed [AccW-1:0]  off6;
  logic [43:0]             pl6;
  logic [43:0]             ph6;

  logic [43:0]        pl_c;
  logic signed [44:0] ph_c;

  // stage 7
  logic                    v7;
  logic                    z7;
  logic signed [TempW-1:0] t2_7;
  logic signed [AccW-1:0]  off7;
  logic signed [63:0]      prod7;

  logic signed [43:0] q_c;

  assign pl_c = second.d1 * second.sens[19:0];
  assign ph_c = $signed({1'b0, second.d1}) * $signed(second.sens[39:20]);
  assign q_c  = $signed({prod7[63], prod7[63:21]}) - $signed({{4{off7[AccW-1]}}, off7});

  always_ff @(posedge clk) begin
    if (rst) begin
      v6        <= 1'b0;
      v7        <= 1'b0;
      done      <= 1'b0;
      valid_res <= 1'b0;
    end else begin
      v6        <= second.vld;
      v7        <= v6;
      done      <= v7;
      valid_res <= v7 & ~z7;
    end
  end

  always_ff @(posedge clk) begin
    z6    <= second.zero;
    t2_6  <= second.t2;
    off6  <= second.off;
    pl6   <= pl_c;
    ph6   <= ph_c[43:0];
    z7    <= z6;
    t2_7  <= t2_6;
    off7  <= off6;
    prod7 <= $signed({ph6, 20'b0}) + $signed({20'b0, pl6});
    temperature_centideg <= z7 ? '0 : t2_7;
    pressure_tens_pa     <= z7 ? '0 : q_c[40:13];
  end

endmodule

// ===== hw/rtl/pressure_temperature_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Second-order integer compensation of raw pressure and temperature counts.
// ----------------------------------------------------------------------------
// An item is taken on every cycle that start is high; busy never rises. The
// result of a transfer appears on done for one cycle, in the order of the
// inputs, one per cycle at full rate. The pipe has eight stages (dT,
// products on dT, first order, squares, second order, partial products,
// product sum, final scaling). The receiver cannot stall the block and
// must take each result in its done cycle. The calibration words are
// written through cfg_we/cfg_index/cfg_data and must not change while
// items are in flight.
module pressure_temperature_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ptc_pkg::CountW-1:0]         pressure_count,
  input  logic [ptc_pkg::CountW-1:0]         temperature_count,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [ptc_pkg::CalW-1:0]           cfg_data,
  output logic                               done,
  output logic                               valid_res,
  output logic signed [ptc_pkg::TempW-1:0]   temperature_centideg,
  output logic signed [ptc_pkg::PressW-1:0]  pressure_tens_pa
);
  import ptc_pkg::*;

  cal_t    cal;
  front_t  front;
  second_t second;
  logic    start_acc;

  assign busy      = 1'b0;
  assign start_acc = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_C1:  cal.c1 <= cfg_data;
        REG_C2:  cal.c2 <= cfg_data;
        REG_C3:  cal.c3 <= cfg_data;
        REG_C4:  cal.c4 <= cfg_data;
        REG_C5:  cal.c5 <= cfg_data;
        REG_C6:  cal.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .start_acc         (start_acc),
    .pressure_count    (pressure_count),
    .temperature_count (temperature_count),
    .cal               (cal),
    .front             (front)
  );

  ptc_second u_second (
    .clk    (clk),
    .rst    (rst),
    .front  (front),
    .second (second)
  );

  ptc_press u_press (
    .clk                  (clk),
    .rst                  (rst),
    .second               (second),
    .done                 (done),
    .valid_res            (valid_res),
    .temperature_centideg (temperature_centideg),
    .pressure_tens_pa     (pressure_tens_pa)
  );

endmodule

// ===== hw/rtl/ptc_checker.sv =====
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [23:0] pressure_count,
  input logic [23:0] temperature_count,
  input logic        done,
  input logic        valid_res,
  input logic [18:0] temperature_centideg,
  input logic [27:0] pressure_tens_pa
);

  // every transfer in gives one result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##8 done)
    else $error("result missing after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 8))
    else $error("result without transfer");

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (pressure_count == 24'd0 || temperature_count == 24'd0))
      |-> ##8 !valid_res)
    else $error("valid flag set for zero count");

  a_zero_outputs: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (temperature_centideg == 19'd0 && pressure_tens_pa == 28'd0))
    else $error("nonzero result on invalid sample");

  a_valid_in_done: assert property (@(posedge clk) disable iff (rst)
    valid_res |-> done)
    else $error("valid flag outside result cycle");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);
